@@ src/lic_pkg.sv @@
package lic_pkg;

    // One character of a literal as it moves from the input register to the scanner.
    typedef struct packed {
        logic [7:0] text_byte;
        logic       final_char;
    } char_t;

    // Register map (register index, byte address = 4 * index).
    localparam int unsigned REG_WIDE_MODE = 0;
    localparam int unsigned CFG_ADDR_W    = 3;

    // Characters the grammar cares about.
    localparam logic [7:0] CHAR_PLUS       = 8'h2B;
    localparam logic [7:0] CHAR_MINUS      = 8'h2D;
    localparam logic [7:0] CHAR_ZERO       = 8'h30;
    localparam logic [7:0] CHAR_NINE       = 8'h39;
    localparam logic [7:0] CHAR_UPPER_A    = 8'h41;
    localparam logic [7:0] CHAR_UPPER_F    = 8'h46;
    localparam logic [7:0] CHAR_UPPER_X    = 8'h58;
    localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CHAR_LOWER_A    = 8'h61;
    localparam logic [7:0] CHAR_LOWER_F    = 8'h66;
    localparam logic [7:0] CHAR_LOWER_X    = 8'h78;

    // Magnitude limits.
    localparam logic [63:0] LIMIT_NEG_32 = 64'h0000_0000_8000_0000;
    localparam logic [63:0] LIMIT_POS_32 = 64'h0000_0000_FFFF_FFFF;
    localparam logic [63:0] LIMIT_NEG_64 = 64'h8000_0000_0000_0000;
    localparam logic [63:0] LIMIT_POS_64 = 64'hFFFF_FFFF_FFFF_FFFF;

    // Digit decode: bit 4 = is a digit of the current base, bits 3:0 = value.
    function automatic logic [4:0] digit_of(input logic [7:0] c, input logic hex);
        logic [7:0] dec_off;
        logic [7:0] low_off;
        logic [7:0] up_off;
        logic [4:0] d;
        dec_off = c - CHAR_ZERO;
        low_off = c - CHAR_LOWER_A + 8'd10;
        up_off  = c - CHAR_UPPER_A + 8'd10;
        d = 5'b0_0000;
        if (c >= CHAR_ZERO && c <= CHAR_NINE)
        begin
            d = {1'b1, dec_off[3:0]};
        end
        else if (hex && c >= CHAR_LOWER_A && c <= CHAR_LOWER_F)
        begin
            d = {1'b1, low_off[3:0]};
        end
        else if (hex && c >= CHAR_UPPER_A && c <= CHAR_UPPER_F)
        begin
            d = {1'b1, up_off[3:0]};
        end
        return d;
    endfunction

endpackage

@@ src/lic_cfg.sv @@
module lic_cfg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [lic_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    output logic                              wide_mode
);

    logic wide_mode_reg;
    logic hit_wide;

    // Register index is paddr[2]; low byte-offset bits are ignored.
    assign hit_wide = (32'(paddr[2]) == lic_pkg::REG_WIDE_MODE);
    assign pready   = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wide_mode_reg <= 1'b0;
        end
        else if (psel && penable && pwrite && hit_wide)
        begin
            wide_mode_reg <= pwdata[0];
        end
    end

    assign prdata    = hit_wide ? {31'b0, wide_mode_reg} : 32'b0;
    assign wide_mode = wide_mode_reg;

endmodule

@@ src/lic_scan.sv @@
module lic_scan (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           step,
    input  lic_pkg::char_t ch,
    input  logic           wide_mode,
    output logic           literal_ok
);

    typedef enum logic [2:0] {
        PH_START  = 3'd0,
        PH_SIGNED = 3'd1,
        PH_LEAD0  = 3'd2,
        PH_HEX0   = 3'd3,
        PH_DIGIT  = 3'd4,
        PH_UNDER  = 3'd5
    } phase_t;

    phase_t      phase_reg, phase_next, phase_eff;
    logic        neg_reg, neg_next;
    logic        hex_reg, hex_next;
    logic [63:0] value_reg, value_next;
    logic        fail_reg, fail_next;

    logic [4:0]  dig;
    logic [67:0] scaled;
    logic [67:0] sum;
    logic [63:0] limit;
    logic        over;
    logic [7:0]  c;

    assign c   = ch.text_byte;
    assign dig = lic_pkg::digit_of(c, hex_reg);

    // value * base + digit, by shifts; compare against the limit in full width
    always_comb
    begin
        if (hex_reg)
        begin
            scaled = {value_reg, 4'b0};
        end
        else
        begin
            scaled = {1'b0, value_reg, 3'b0} + {3'b0, value_reg, 1'b0};
        end
        sum = scaled + {64'b0, dig[3:0]};
        if (wide_mode)
        begin
            limit = neg_reg ? lic_pkg::LIMIT_NEG_64 : lic_pkg::LIMIT_POS_64;
        end
        else
        begin
            limit = neg_reg ? lic_pkg::LIMIT_NEG_32 : lic_pkg::LIMIT_POS_32;
        end
        over = (sum > {4'b0, limit});
    end

    always_comb
    begin
        phase_next = phase_reg;
        neg_next   = neg_reg;
        hex_next   = hex_reg;
        value_next = value_reg;
        fail_next  = fail_reg;
        phase_eff  = phase_reg;
        literal_ok = 1'b0;

        if (!fail_reg)
        begin
            if (phase_reg == PH_START)
            begin
                phase_eff = PH_SIGNED;
            end
            if (phase_reg == PH_START &&
                (c == lic_pkg::CHAR_PLUS || c == lic_pkg::CHAR_MINUS))
            begin
                neg_next   = (c == lic_pkg::CHAR_MINUS);
                phase_next = PH_SIGNED;
            end
            else
            begin
                case (phase_eff)
                    PH_SIGNED:
                    begin
                        phase_next = (c == lic_pkg::CHAR_ZERO) ? PH_LEAD0 : PH_DIGIT;
                    end
                    PH_LEAD0, PH_DIGIT:
                    begin
                        phase_next = PH_DIGIT;
                    end
                    PH_HEX0, PH_UNDER:
                    begin
                        phase_next = PH_DIGIT;
                    end
                    default:
                    begin
                        phase_next = phase_eff;
                    end
                endcase

                if (phase_eff == PH_LEAD0 &&
                    (c == lic_pkg::CHAR_LOWER_X || c == lic_pkg::CHAR_UPPER_X))
                begin
                    hex_next   = 1'b1;
                    phase_next = PH_HEX0;
                end
                else if ((phase_eff == PH_LEAD0 || phase_eff == PH_DIGIT) &&
                         c == lic_pkg::CHAR_UNDERSCORE)
                begin
                    phase_next = PH_UNDER;
                end
                else if (phase_eff == PH_SIGNED || phase_eff == PH_LEAD0 ||
                         phase_eff == PH_DIGIT || phase_eff == PH_HEX0 ||
                         phase_eff == PH_UNDER)
                begin
                    if (!dig[4])
                    begin
                        fail_next  = 1'b1;
                        phase_next = phase_eff;
                    end
                    else if (over)
                    begin
                        fail_next = 1'b1;
                    end
                    else
                    begin
                        value_next = sum[63:0];
                    end
                end
                else
                begin
                    // unreachable phase codes
                    fail_next = 1'b1;
                end
            end
        end

        literal_ok = !fail_next && (phase_next == PH_LEAD0 || phase_next == PH_DIGIT);

        if (ch.final_char)
        begin
            phase_next = PH_START;
            neg_next   = 1'b0;
            hex_next   = 1'b0;
            value_next = 64'b0;
            fail_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_START;
            neg_reg   <= 1'b0;
            hex_reg   <= 1'b0;
            value_reg <= 64'b0;
            fail_reg  <= 1'b0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            neg_reg   <= neg_next;
            hex_reg   <= hex_next;
            value_reg <= value_next;
            fail_reg  <= fail_next;
        end
    end

endmodule

@@ src/integer_literal_checker_top.sv @@
// Channel | Dir | Handshake            | Payload
// --------+-----+----------------------+------------------------------
// in      | in  | in_valid / in_ready  | text_byte[7:0], final_char
// out     | out | out_valid / out_ready| literal_ok
// cfg     | in  | APB psel/penable     | wide_mode at byte address 0
//
// One character per cycle sustained while no final character waits on a
// pending result; the rate rests on the scan state update (value * base +
// digit and limit compare) being combinational. A result shows on out_valid
// after the final character's transaction: the character sits in the input
// register until the result slot is free, then the result register loads.
// Reset clears the literal state, wide_mode and both valid flags; no sweep.
// A pending result stalls only a final character; non-final characters keep
// flowing while out_ready is low until the next final one reaches the input
// register, which then holds and drops in_ready.
module integer_literal_checker_top (
    input  logic                           clk,
    input  logic                           rst_n,

    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [7:0]                     text_byte,
    input  logic                           final_char,

    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           literal_ok,

    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [lic_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    logic           wide_mode;

    // input register
    logic           s1_valid_reg;
    lic_pkg::char_t s1_char_reg;
    logic           s1_go;

    // result register
    logic           out_valid_reg;
    logic           ok_reg;
    logic           scan_ok;

    lic_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .wide_mode (wide_mode)
    );

    // A non-final character never waits; a final one needs a free result slot
    // (or one being emptied this cycle).
    assign s1_go    = s1_valid_reg &&
                      (!s1_char_reg.final_char || !out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_char_reg.text_byte  <= text_byte;
            s1_char_reg.final_char <= final_char;
        end
    end

    lic_scan u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (s1_go),
        .ch         (s1_char_reg),
        .wide_mode  (wide_mode),
        .literal_ok (scan_ok)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_go && s1_char_reg.final_char)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go && s1_char_reg.final_char)
        begin
            ok_reg <= scan_ok;
        end
    end

    assign out_valid  = out_valid_reg;
    assign literal_ok = ok_reg;

endmodule

@@ tb/sv/integer_literal_checker_top_tb.sv @@
module integer_literal_checker_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Scanner phases of the literal grammar, encoded as the block keeps them.
    typedef enum logic [2:0] {
        SCAN_IDLE   = 3'd0,   // nothing seen yet: sign or digit may come
        SCAN_SIGN   = 3'd1,   // sign seen, first digit expected
        SCAN_ZERO   = 3'd2,   // a single leading zero: 'x'/'X' may follow
        SCAN_PREFIX = 3'd3,   // hex prefix seen, a digit must follow
        SCAN_DIGITS = 3'd4,   // inside the digit run
        SCAN_SEP    = 3'd5    // underscore seen, a digit must follow
    } scan_state_t;

    typedef logic [lic_pkg::CFG_ADDR_W-1:0] cfg_addr_t;

    localparam cfg_addr_t WIDE_MODE_ADDR = cfg_addr_t'(lic_pkg::REG_WIDE_MODE * 4);

    // DUT ports
    logic                           clk;
    logic                           rst_n;
    logic                           in_valid;
    logic                           in_ready;
    logic [7:0]                     text_byte;
    logic                           final_char;
    logic                           out_valid;
    logic                           out_ready;
    logic                           literal_ok;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [lic_pkg::CFG_ADDR_W-1:0] paddr;
    logic [31:0]                    pwdata;
    logic [31:0]                    prdata;
    logic                           pready;

    // Literal scanner model: its own copy of the state and of wide_mode.
    scan_state_t lit_state;
    bit          lit_neg;
    bit          lit_hex;
    bit          lit_fail;
    logic [63:0] lit_value;
    bit          wide_sel;

    // Verdicts predicted for literals whose final character went in.
    bit          verdict_q[$];

    // Text of the next literal to send.
    byte unsigned text_buf[$];

    // Traffic shaping knobs, flipped per phase.
    bit          send_gaps;
    bit          take_gaps;
    int unsigned out_hold_cycles;

    int unsigned fail_count;
    int unsigned chars_sent;
    int unsigned verdicts_checked;
    int unsigned verdicts_ok;
    bit          verdict_want;

    integer_literal_checker_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .text_byte  (text_byte),
        .final_char (final_char),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .literal_ok (literal_ok),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop in case a handshake never completes.
    initial
    begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    //------------------------------------------------------------------
    // Scanner model
    //------------------------------------------------------------------

    function automatic void clear_literal_model();
        lit_state = SCAN_IDLE;
        lit_neg   = 1'b0;
        lit_hex   = 1'b0;
        lit_fail  = 1'b0;
        lit_value = '0;
    endfunction

    // Value of c as a digit of the current base, -1 when it is none.
    function automatic int digit_value(input logic [7:0] c, input bit hex);
        int v;
        v = -1;
        if (c >= lic_pkg::CHAR_ZERO && c <= lic_pkg::CHAR_NINE)
        begin
            v = int'(c) - int'(lic_pkg::CHAR_ZERO);
        end
        else if (hex && c >= lic_pkg::CHAR_LOWER_A && c <= lic_pkg::CHAR_LOWER_F)
        begin
            v = int'(c) - int'(lic_pkg::CHAR_LOWER_A) + 10;
        end
        else if (hex && c >= lic_pkg::CHAR_UPPER_A && c <= lic_pkg::CHAR_UPPER_F)
        begin
            v = int'(c) - int'(lic_pkg::CHAR_UPPER_A) + 10;
        end
        return v;
    endfunction

    // Multiply-add one digit, or mark overflow if the limit would be passed.
    // The limit follows wide_mode as it stands when the digit arrives.
    function automatic void accumulate_digit(input int d);
        logic [63:0] bound;
        logic [63:0] radix;
        logic [63:0] dig;
        radix = lit_hex ? 64'd16 : 64'd10;
        dig   = 64'(d);
        if (wide_sel)
        begin
            bound = lit_neg ? lic_pkg::LIMIT_NEG_64 : lic_pkg::LIMIT_POS_64;
        end
        else
        begin
            bound = lit_neg ? lic_pkg::LIMIT_NEG_32 : lic_pkg::LIMIT_POS_32;
        end
        if (lit_value > (bound - dig) / radix)
        begin
            lit_fail = 1'b1;
        end
        else
        begin
            lit_value = lit_value * radix + dig;
        end
    endfunction

    // Advance the model by one accepted character; a final character queues
    // the verdict and rearms the scanner for the next literal.
    function automatic void predict_char(input logic [7:0] c, input logic last);
        int d;
        if (!lit_fail)
        begin
            if (lit_state == SCAN_IDLE &&
                (c == lic_pkg::CHAR_PLUS || c == lic_pkg::CHAR_MINUS))
            begin
                lit_neg   = (c == lic_pkg::CHAR_MINUS);
                lit_state = SCAN_SIGN;
            end
            else
            begin
                if (lit_state == SCAN_IDLE)
                begin
                    lit_state = SCAN_SIGN;
                end
                d = digit_value(c, lit_hex);
                case (lit_state)
                    SCAN_SIGN:
                    begin
                        if (d < 0)
                        begin
                            lit_fail = 1'b1;
                        end
                        else
                        begin
                            accumulate_digit(d);
                            lit_state = (c == lic_pkg::CHAR_ZERO) ? SCAN_ZERO : SCAN_DIGITS;
                        end
                    end
                    SCAN_ZERO, SCAN_DIGITS:
                    begin
                        if (lit_state == SCAN_ZERO &&
                            (c == lic_pkg::CHAR_LOWER_X || c == lic_pkg::CHAR_UPPER_X))
                        begin
                            lit_hex   = 1'b1;
                            lit_state = SCAN_PREFIX;
                        end
                        else if (c == lic_pkg::CHAR_UNDERSCORE)
                        begin
                            lit_state = SCAN_SEP;
                        end
                        else if (d < 0)
                        begin
                            lit_fail = 1'b1;
                        end
                        else
                        begin
                            accumulate_digit(d);
                            lit_state = SCAN_DIGITS;
                        end
                    end
                    SCAN_PREFIX, SCAN_SEP:
                    begin
                        if (d < 0)
                        begin
                            lit_fail = 1'b1;
                        end
                        else
                        begin
                            accumulate_digit(d);
                            lit_state = SCAN_DIGITS;
                        end
                    end
                    default:
                    begin
                        lit_fail = 1'b1;
                    end
                endcase
            end
        end
        if (last)
        begin
            verdict_q.push_back(!lit_fail && (lit_state == SCAN_ZERO || lit_state == SCAN_DIGITS));
            clear_literal_model();
        end
    endfunction

    //------------------------------------------------------------------
    // Input side
    //------------------------------------------------------------------

    // Offer one character. Entered and left at a falling edge; valid stays
    // high on return so a back-to-back transaction never drops it.
    task automatic send_char(input logic [7:0] c, input logic last);
        int unsigned gap;
        gap = send_gaps ? $urandom_range(0, 8) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        text_byte  <= c;
        final_char <= last;
        do
            @(posedge clk);
        while (!in_ready);
        predict_char(c, last);
        chars_sent++;
        @(negedge clk);
    endtask

    // Drop valid; only called at a falling edge.
    task automatic stop_sending();
        in_valid <= 1'b0;
    endtask

    task automatic send_text(input string s, input bit ends);
        for (int i = 0; i < s.len(); i++)
        begin
            send_char(s[i], ends && (i == s.len() - 1));
        end
    endtask

    task automatic send_literal();
        for (int i = 0; i < text_buf.size(); i++)
        begin
            send_char(text_buf[i], i == text_buf.size() - 1);
        end
    endtask

    // Quiesce: nothing pending on the output, then wait until a non-final
    // character still in the input register has been scanned.
    task automatic drain_block();
        stop_sending();
        while (verdict_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(negedge clk);
    endtask

    // APB write of wide_mode followed by a read back of the same register.
    task automatic write_wide_mode(input bit mode);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= WIDE_MODE_ADDR;
        pwdata  <= {31'd0, mode};
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        wide_sel = mode;
        @(negedge clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata[0] !== mode)
        begin
            $error("wide_mode read back: expected %0b actual %0b", mode, prdata[0]);
            fail_count++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    //------------------------------------------------------------------
    // Literal generation
    //------------------------------------------------------------------

    // Append v in the given base, hex letters in random case, with an
    // occasional single underscore between two digits.
    function automatic void push_digits(input logic [69:0] v, input bit hex);
        byte unsigned rev[$];
        logic [69:0]  radix;
        int unsigned  d;
        logic [7:0]   letter_a;
        radix = hex ? 70'd16 : 70'd10;
        do
        begin
            d = int'(v % radix);
            if (d < 10)
            begin
                rev.push_back(8'(lic_pkg::CHAR_ZERO + d));
            end
            else
            begin
                letter_a = $urandom_range(0, 1) ? lic_pkg::CHAR_UPPER_A : lic_pkg::CHAR_LOWER_A;
                rev.push_back(8'(letter_a + d - 10));
            end
            v = v / radix;
        end
        while (v != 0);
        for (int i = rev.size() - 1; i >= 0; i--)
        begin
            text_buf.push_back(rev[i]);
            if (i > 0 && $urandom_range(0, 7) == 0)
            begin
                text_buf.push_back(lic_pkg::CHAR_UNDERSCORE);
            end
        end
    endfunction

    // Characters the grammar reacts to, for noise that still hits the decoder.
    function automatic logic [7:0] grammar_char();
        logic [7:0] c;
        case ($urandom_range(0, 7))
            0:       c = lic_pkg::CHAR_PLUS;
            1:       c = lic_pkg::CHAR_MINUS;
            2:       c = lic_pkg::CHAR_ZERO;
            3:       c = lic_pkg::CHAR_LOWER_X;
            4:       c = lic_pkg::CHAR_UPPER_X;
            5:       c = lic_pkg::CHAR_UNDERSCORE;
            6:       c = lic_pkg::CHAR_NINE;
            default: c = lic_pkg::CHAR_UPPER_F;
        endcase
        return c;
    endfunction

    // Well-formed literal; about half sit within two of the limit of the current
    // mode, or carry one digit too many.
    function automatic void build_good_literal();
        int unsigned sign_kind;
        int unsigned kind;
        bit          neg;
        bit          hex;
        logic [69:0] lim;
        logic [69:0] v;
        text_buf.delete();
        sign_kind = $urandom_range(0, 2);
        neg       = (sign_kind == 2);
        if (sign_kind == 1)
        begin
            text_buf.push_back(lic_pkg::CHAR_PLUS);
        end
        else if (neg)
        begin
            text_buf.push_back(lic_pkg::CHAR_MINUS);
        end
        hex = ($urandom_range(0, 9) < 4);
        if (hex)
        begin
            text_buf.push_back(lic_pkg::CHAR_ZERO);
            text_buf.push_back($urandom_range(0, 1) ? lic_pkg::CHAR_UPPER_X
                                                    : lic_pkg::CHAR_LOWER_X);
        end
        if (wide_sel)
        begin
            lim = 70'(neg ? lic_pkg::LIMIT_NEG_64 : lic_pkg::LIMIT_POS_64);
        end
        else
        begin
            lim = 70'(neg ? lic_pkg::LIMIT_NEG_32 : lic_pkg::LIMIT_POS_32);
        end
        kind = $urandom_range(0, 9);
        if (kind < 3)
        begin
            v = 70'($urandom_range(0, 999));
        end
        else if (kind < 5)
        begin
            v = 70'({$urandom, $urandom}) >> $urandom_range(0, 63);
        end
        else if (kind < 9)
        begin
            v = lim + 70'($urandom_range(0, 4));
            v = v - 70'd2;
        end
        else
        begin
            // one digit too many: overflow no matter which digit
            v = lim * (hex ? 70'd16 : 70'd10) + 70'($urandom_range(0, hex ? 15 : 9));
        end
        if ($urandom_range(0, 5) == 0)
        begin
            repeat ($urandom_range(1, 2)) text_buf.push_back(lic_pkg::CHAR_ZERO);
        end
        push_digits(v, hex);
    endfunction

    // Broken literal: a damaged well-formed one, or plain noise.
    function automatic void build_bad_literal();
        int unsigned cut;
        build_good_literal();
        case ($urandom_range(0, 4))
            0: text_buf[$urandom_range(0, text_buf.size() - 1)] = 8'($urandom_range(0, 255));
            1:
            begin
                cut = $urandom_range(0, text_buf.size());
                text_buf.insert(cut, lic_pkg::CHAR_UNDERSCORE);
                text_buf.insert(cut, lic_pkg::CHAR_UNDERSCORE);
            end
            2:
            begin
                cut = $urandom_range(1, text_buf.size());
                while (text_buf.size() > cut)
                begin
                    void'(text_buf.pop_back());
                end
            end
            3: text_buf.push_back(lic_pkg::CHAR_UNDERSCORE);
            default:
            begin
                text_buf.delete();
                repeat ($urandom_range(1, 5))
                begin
                    text_buf.push_back($urandom_range(0, 1) ? 8'($urandom_range(0, 255))
                                                            : grammar_char());
                end
            end
        endcase
    endfunction

    //------------------------------------------------------------------
    // Output side
    //------------------------------------------------------------------

    // Receiver: random stall before each transaction, or one long hold-off
    // when a test asks for it.
    initial
    begin : receiver
        int unsigned stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = take_gaps ? $urandom_range(0, 8) : 0;
            if (out_hold_cycles > 0)
            begin
                stall = out_hold_cycles;
                out_hold_cycles = 0;
            end
            if (stall > 0)
            begin
                @(negedge clk);
                out_ready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            @(negedge clk);
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    // Every output transaction is matched against the oldest predicted verdict.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (verdict_q.size() == 0)
            begin
                $error("literal_ok: unexpected transaction, actual %0b", literal_ok);
                fail_count++;
            end
            else
            begin
                verdict_want = verdict_q.pop_front();
                verdicts_checked++;
                if (verdict_want)
                begin
                    verdicts_ok++;
                end
                if (literal_ok !== verdict_want)
                begin
                    $error("literal_ok: expected %0b actual %0b", verdict_want, literal_ok);
                    fail_count++;
                end
            end
        end
    end

    //------------------------------------------------------------------
    // Tests
    //------------------------------------------------------------------

    // Short grammar corner cases in 32-bit mode: lone zeros, bare prefix,
    // underscore placement, bad digits after the prefix, bytes 0x00 and 0xFF,
    // a sign with nothing after it, and a bad character after a digit.
    task automatic test_directed_cases();
        send_gaps = 1'b0;
        take_gaps = 1'b0;
        write_wide_mode(1'b0);
        send_text("0", 1'b1);
        send_text("-0", 1'b1);
        send_text("0x", 1'b1);
        send_text("0Xf", 1'b1);
        send_text("1_2", 1'b1);
        send_text("_1", 1'b1);
        send_text("1_", 1'b1);
        send_text("0xg", 1'b1);
        send_char(8'h00, 1'b1);
        send_char(8'hFF, 1'b1);
        send_text("+", 1'b1);
        send_text("9z", 1'b1);
        drain_block();
    endtask

    // wide_mode flips between digits of one literal; each digit is judged
    // against the limit in force when it arrives.
    task automatic test_mode_switch_mid_literal();
        // 4294967296 overflows 32 bits only on its last digit
        send_text("429496729", 1'b0);
        drain_block();
        write_wide_mode(1'b1);
        send_text("6", 1'b1);
        send_text("-42949672", 1'b0);
        drain_block();
        write_wide_mode(1'b0);
        send_text("96", 1'b1);
        drain_block();
    endtask

    // Bulk traffic over several mode settings, with idle stretches on either
    // side switched on and off per phase. Mostly well-formed literals.
    task automatic test_random_traffic(input int unsigned char_budget);
        int unsigned phase_start;
        for (int p = 0; p < 6; p++)
        begin
            drain_block();
            write_wide_mode(p inside {1, 3, 4});
            send_gaps = (p % 3) != 2;
            take_gaps = (p % 3) != 1;
            phase_start = chars_sent;
            while (chars_sent - phase_start < char_budget / 6)
            begin
                if ($urandom_range(0, 9) < 8)
                begin
                    build_good_literal();
                end
                else
                begin
                    build_bad_literal();
                end
                send_literal();
            end
        end
        drain_block();
    endtask

    // Receiver stops for a long while; the result register fills and the
    // block has to stall final characters while input keeps coming.
    task automatic test_output_backpressure();
        send_gaps = 1'b0;
        take_gaps = 1'b1;
        out_hold_cycles = 300;
        repeat (40)
        begin
            build_good_literal();
            send_literal();
        end
        drain_block();
    endtask

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        text_byte  = '0;
        final_char = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        send_gaps  = 1'b0;
        take_gaps  = 1'b0;
        out_hold_cycles  = 0;
        fail_count       = 0;
        chars_sent       = 0;
        verdicts_checked = 0;
        verdicts_ok      = 0;
        wide_sel = 1'b0;
        clear_literal_model();

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed_cases();
        test_mode_switch_mid_literal();
        test_random_traffic(1000);
        test_output_backpressure();

        stop_sending();
        while (verdict_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);

        $display("covered %0d characters, %0d literals judged (%0d accepted)",
                 chars_sent, verdicts_checked, verdicts_ok);
        $display("in 32- and 64-bit modes, near the limits, with mode flips and output stalls");
        if (fail_count == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
